// ===== src/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_DONE   = 3'd1;
  localparam logic [2:0] KIND_TOKEN  = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_NOTSTR = 3'd4;

  localparam int unsigned MAX_RES = 3;

  // results of one item, entry 0 goes out first
  typedef struct packed {
    logic [1:0]                cnt;
    logic [MAX_RES-1:0][7:0]   bytes;
    logic [MAX_RES-1:0][2:0]   kinds;
  } res_t;

endpackage
`default_nettype wire

// ===== src/jsu_decode.sv =====
`default_nettype none
module jsu_decode (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         take,
  input  wire logic [7:0]   in_byte,
  input  wire logic         is_end,
  output jsu_pkg::res_t     res
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     hex_r, hex_nxt;
  logic [15:0]    cp_r, cp_nxt;

  logic           hex_ok;
  logic [3:0]     hex_val;
  logic [15:0]    cp_new;
  logic           esc_ok;
  logic [7:0]     esc_char;
  logic           is_ctrl;
  logic           open;
  jsu_pkg::res_t  raw;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_new  = {cp_r[11:0], hex_val};
  assign is_ctrl = (in_byte <= 8'h1f) || (in_byte == CH_DEL);

  always_comb begin
    esc_ok   = 1'b1;
    esc_char = 8'h00;
    case (in_byte)
      CH_QUOTE: esc_char = CH_QUOTE;
      CH_BSL:   esc_char = CH_BSL;
      CH_SLASH: esc_char = CH_SLASH;
      CH_B:     esc_char = 8'h08;
      CH_F:     esc_char = 8'h0c;
      CH_N:     esc_char = 8'h0a;
      CH_R:     esc_char = 8'h0d;
      CH_T:     esc_char = 8'h09;
      default:  esc_ok   = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    cp_nxt   = cp_r;
    unique case (mode_r)
      jsu_pkg::MODE_IDLE: begin
        if (in_byte == CH_QUOTE) mode_nxt = jsu_pkg::MODE_STR;
      end
      jsu_pkg::MODE_STR: begin
        if (in_byte == CH_QUOTE || is_ctrl) mode_nxt = jsu_pkg::MODE_IDLE;
        else if (in_byte == CH_BSL) mode_nxt = jsu_pkg::MODE_ESC;
      end
      jsu_pkg::MODE_ESC: begin
        if (esc_ok) begin
          mode_nxt = jsu_pkg::MODE_STR;
        end else if (in_byte == CH_U) begin
          mode_nxt = jsu_pkg::MODE_HEX;
          hex_nxt  = 2'd0;
          cp_nxt   = 16'h0000;
        end else begin
          mode_nxt = jsu_pkg::MODE_IDLE;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hex_ok) begin
          mode_nxt = jsu_pkg::MODE_IDLE;
          hex_nxt  = 2'd0;
          cp_nxt   = 16'h0000;
        end else if (hex_r == 2'd3) begin
          mode_nxt = jsu_pkg::MODE_STR;
          hex_nxt  = 2'd0;
          cp_nxt   = 16'h0000;
        end else begin
          hex_nxt = hex_r + 2'd1;
          cp_nxt  = cp_new;
        end
      end
      default: mode_nxt = jsu_pkg::MODE_IDLE;
    endcase
    if (is_end) begin
      mode_nxt = jsu_pkg::MODE_IDLE;
      hex_nxt  = 2'd0;
      cp_nxt   = 16'h0000;
    end
  end

  // results
  always_comb begin
    raw  = '0;
    open = 1'b0;
    unique case (mode_r)
      jsu_pkg::MODE_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          open = 1'b1;
        end else begin
          raw.cnt      = 2'd1;
          raw.kinds[0] = jsu_pkg::KIND_NOTSTR;
        end
      end
      jsu_pkg::MODE_STR: begin
        if (in_byte == CH_QUOTE) begin
          raw.cnt      = 2'd1;
          raw.kinds[0] = jsu_pkg::KIND_DONE;
        end else if (in_byte == CH_BSL) begin
          open = 1'b1;
        end else if (is_ctrl) begin
          raw.cnt      = 2'd1;
          raw.kinds[0] = jsu_pkg::KIND_TOKEN;
        end else begin
          raw.cnt      = 2'd1;
          raw.bytes[0] = in_byte;
          open         = 1'b1;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (esc_ok) begin
          raw.cnt      = 2'd1;
          raw.bytes[0] = esc_char;
          open         = 1'b1;
        end else if (in_byte == CH_U) begin
          open = 1'b1;
        end else begin
          raw.cnt      = 2'd1;
          raw.kinds[0] = jsu_pkg::KIND_TOKEN;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hex_ok) begin
          raw.cnt      = 2'd1;
          raw.kinds[0] = jsu_pkg::KIND_TOKEN;
        end else begin
          open = 1'b1;
          if (hex_r == 2'd3) begin
            // utf-8 encoding of the code point, one to three bytes
            if (cp_new < 16'h0080) begin
              raw.cnt      = 2'd1;
              raw.bytes[0] = cp_new[7:0];
            end else if (cp_new < 16'h0800) begin
              raw.cnt      = 2'd2;
              raw.bytes[0] = {3'b110, cp_new[10:6]};
              raw.bytes[1] = {2'b10, cp_new[5:0]};
            end else begin
              raw.cnt      = 2'd3;
              raw.bytes[0] = {4'b1110, cp_new[15:12]};
              raw.bytes[1] = {2'b10, cp_new[11:6]};
              raw.bytes[2] = {2'b10, cp_new[5:0]};
            end
          end
        end
      end
      default: raw = '0;
    endcase
    res = raw;
    // string still open at end of input replaces everything else
    if (is_end && open) begin
      res          = '0;
      res.cnt      = 2'd1;
      res.kinds[0] = jsu_pkg::KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_IDLE;
      hex_r  <= 2'd0;
      cp_r   <= 16'h0000;
    end else if (take) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      cp_r   <= cp_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/json_string_unescape_top.sv =====
`default_nettype none
// channel   ports                                      direction
// in        in_valid in_ready in_byte in_is_end        sink
// out       out_valid out_ready out_byte out_kind out_last   source
//
// one input byte per cycle; an item is held in an input register and decoded
// into a result register of up to three entries in one pass
// items that give one or no result sustain one per cycle unless stalled;
// a \u escape that needs two or three utf-8 bytes holds the input while the
// result register drains
// synchronous active-low reset returns to idle outside any string
// out_ready low stalls the result register and then the input register
module json_string_unescape_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_is_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic            out_last
);

  logic                    in_v_r;
  logic [7:0]              in_byte_r;
  logic                    in_end_r;

  logic [1:0]              cnt_r;
  logic [jsu_pkg::MAX_RES-1:0][7:0] bytes_r;
  logic [jsu_pkg::MAX_RES-1:0][2:0] kinds_r;

  jsu_pkg::res_t           dec;
  logic                    move;
  logic                    pop;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (move),
    .in_byte (in_byte_r),
    .is_end  (in_end_r),
    .res     (dec)
  );

  assign pop      = out_valid && out_ready;
  // the held item moves once the result register can take its results
  assign move     = in_v_r && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready) ||
                               (dec.cnt == 2'd0));
  assign in_ready = !in_v_r || move;

  assign out_valid = (cnt_r != 2'd0);
  assign out_byte  = bytes_r[0];
  assign out_kind  = kinds_r[0];
  assign out_last  = (cnt_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
      in_end_r  <= in_is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (move && dec.cnt != 2'd0) begin
      cnt_r <= dec.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && dec.cnt != 2'd0) begin
      bytes_r <= dec.bytes;
      kinds_r <= dec.kinds;
    end else if (pop) begin
      bytes_r[0] <= bytes_r[1];
      bytes_r[1] <= bytes_r[2];
      kinds_r[0] <= kinds_r[1];
      kinds_r[1] <= kinds_r[2];
    end
  end

endmodule
`default_nettype wire
